### design/hpq_pkg.sv
// ----------------------------------------------------------------------------
// hpq_pkg: shared types and constants of the binary heap priority queue
// Holds the sizing constants, the opcodes, the entry layout, the result and memory
// request structs, the result status codes, the controller states and the priority compare.
// ----------------------------------------------------------------------------
package hpq_pkg;

    localparam int DEPTH  = 1024;
    localparam int KEY_W  = 32;
    localparam int PAY_W  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    // Child indices can reach 2*DEPTH, so they carry two extra bits.
    localparam int CH_W   = ADDR_W + 2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_LAST,
        S_POP_CARRY,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RL,
        S_DN_RR,
        S_DN_CMP
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
    } mem_req_t;

    typedef struct packed {
        logic             valid;
        status_t          status;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        logic [CNT_W-1:0] count;
    } res_t;

    // True when key a must be served strictly before key b.
    function automatic logic outranks(input logic [KEY_W-1:0] a,
                                      input logic [KEY_W-1:0] b,
                                      input logic smallest_first);
        logic r;
        r = smallest_first ? (a < b) : (a > b);
        return r;
    endfunction

endpackage

### design/hpq_ram.sv
// ----------------------------------------------------------------------------
// hpq_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered, valid in the cycle after the read.
// ----------------------------------------------------------------------------
module hpq_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 64
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    localparam int WORDS = 2 ** ADDR_W;

    logic [DATA_W-1:0] mem [WORDS];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/hpq_ctrl.sv
// ----------------------------------------------------------------------------
// hpq_ctrl: heap sequencer
// Runs push (sift up) and pop (sift down) over the entry memory, carrying the
// moving entry in a register so each level costs one write.
// ----------------------------------------------------------------------------
module hpq_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     opcode,
    input  logic [hpq_pkg::KEY_W-1:0] key_in,
    input  logic [hpq_pkg::PAY_W-1:0] payload_in,
    input  logic                     smallest_first,
    input  hpq_pkg::entry_t          rd_data,
    output logic                     busy,
    output hpq_pkg::mem_req_t        mem_req,
    output hpq_pkg::res_t            res
);

    import hpq_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [ADDR_W-1:0]  node_reg;
    entry_t             carry_reg;
    entry_t             popped_reg;
    entry_t             cand_reg;
    logic [ADDR_W-1:0]  cand_idx_reg;
    logic               cand_is_node_reg;

    logic               start_acc;
    logic               pop_fail;
    logic               push_fail;
    logic [CH_W-1:0]    left_w;
    logic [CH_W-1:0]    right_w;
    logic               left_ok;
    logic               right_ok;
    logic [ADDR_W-1:0]  node_m1;
    logic [ADDR_W-1:0]  parent;
    logic               up_swap;
    logic               dn_left_wins;
    logic               dn_right_wins;
    logic               best_node;

    assign start_acc = start && (state_reg == S_IDLE);
    assign pop_fail  = (opcode == OP_POP) && (count_reg == '0);
    assign push_fail = (opcode == OP_PUSH) && (count_reg == CNT_W'(DEPTH));
    assign busy      = (state_reg != S_IDLE);

    assign left_w   = CH_W'({node_reg, 1'b1});
    assign right_w  = left_w + CH_W'(1);
    assign left_ok  = left_w < CH_W'(count_reg);
    assign right_ok = right_w < CH_W'(count_reg);
    assign node_m1  = node_reg - ADDR_W'(1);
    assign parent   = {1'b0, node_m1[ADDR_W-1:1]};

    assign up_swap       = outranks(carry_reg.key, rd_data.key, smallest_first);
    assign dn_left_wins  = outranks(rd_data.key, carry_reg.key, smallest_first);
    assign dn_right_wins = right_ok && outranks(rd_data.key, cand_reg.key, smallest_first);
    assign best_node     = !dn_right_wins && cand_is_node_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (start_acc && !pop_fail && !push_fail)
            begin
                if (opcode == OP_POP)
                begin
                    count_reg <= count_reg - CNT_W'(1);
                end
                else
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
        end
    end

    // Datapath registers; every one is written before it is read.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (start_acc)
                begin
                    popped_reg <= '0;
                    carry_reg  <= '{key: key_in, payload: payload_in};
                    node_reg   <= count_reg[ADDR_W-1:0];
                end
            end
            S_POP_LAST:
            begin
                popped_reg <= rd_data;
            end
            S_POP_CARRY:
            begin
                carry_reg <= rd_data;
                node_reg  <= '0;
            end
            S_UP_CMP:
            begin
                if (up_swap)
                begin
                    node_reg <= parent;
                end
            end
            S_DN_RR:
            begin
                // The candidate is the better of the carried entry and the left child.
                cand_reg         <= dn_left_wins ? rd_data : carry_reg;
                cand_idx_reg     <= left_w[ADDR_W-1:0];
                cand_is_node_reg <= !dn_left_wins;
            end
            S_DN_CMP:
            begin
                if (!best_node)
                begin
                    node_reg <= dn_right_wins ? right_w[ADDR_W-1:0] : cand_idx_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start_acc && !pop_fail && !push_fail)
                begin
                    state_next = (opcode == OP_POP) ? S_POP_LAST : S_UP_RD;
                end
            end
            S_POP_LAST:  state_next = S_POP_CARRY;
            S_POP_CARRY: state_next = (count_reg == '0) ? S_IDLE : S_DN_RL;
            S_UP_RD:     state_next = (node_reg == '0) ? S_IDLE : S_UP_CMP;
            S_UP_CMP:    state_next = up_swap ? S_UP_RD : S_IDLE;
            S_DN_RL:     state_next = left_ok ? S_DN_RR : S_IDLE;
            S_DN_RR:     state_next = S_DN_CMP;
            S_DN_CMP:    state_next = best_node ? S_IDLE : S_DN_RL;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        mem_req         = '0;
        res.valid       = 1'b0;
        res.status      = ST_OK;
        res.key         = popped_reg.key;
        res.payload     = popped_reg.payload;
        res.count       = count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                res.key     = '0;
                res.payload = '0;
                if (start_acc)
                begin
                    if (pop_fail)
                    begin
                        res.valid  = 1'b1;
                        res.status = ST_EMPTY;
                    end
                    else if (push_fail)
                    begin
                        res.valid  = 1'b1;
                        res.status = ST_FULL;
                    end
                    else if (opcode == OP_POP)
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = '0;
                    end
                end
            end
            S_POP_LAST:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = count_reg[ADDR_W-1:0];
            end
            S_POP_CARRY:
            begin
                res.valid = (count_reg == '0);
            end
            S_UP_RD:
            begin
                if (node_reg == '0)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = node_reg;
                    mem_req.wr_data = carry_reg;
                    res.valid       = 1'b1;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = parent;
                end
            end
            S_UP_CMP:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = node_reg;
                mem_req.wr_data = up_swap ? rd_data : carry_reg;
                res.valid       = !up_swap;
            end
            S_DN_RL:
            begin
                if (left_ok)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = left_w[ADDR_W-1:0];
                end
                else
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = node_reg;
                    mem_req.wr_data = carry_reg;
                    res.valid       = 1'b1;
                end
            end
            S_DN_RR:
            begin
                mem_req.rd_en   = right_ok;
                mem_req.rd_addr = right_w[ADDR_W-1:0];
            end
            S_DN_CMP:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = node_reg;
                if (best_node)
                begin
                    mem_req.wr_data = carry_reg;
                    res.valid       = 1'b1;
                end
                else if (dn_right_wins)
                begin
                    mem_req.wr_data = rd_data;
                end
                else
                begin
                    mem_req.wr_data = cand_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // The sequencer never reads and writes the memory in the same cycle.
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.rd_en && mem_req.wr_en))
        else $error("memory read and write issued together");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |=> (state_reg == S_IDLE))
        else $error("sequencer busy after finishing a transaction");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> (state_reg != S_IDLE))
        else $error("memory written while idle");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> $stable(count_reg))
        else $error("entry count changed during a sift");

endmodule

### design/binary_heap_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_unit: binary heap priority queue of 1024 entries
//
// Usage. Drive opcode (0 push, 1 pop), key_in and payload_in with start high;
// the transaction is accepted at a clock edge where start is high and busy is
// low. Each accepted transaction returns exactly one result: result_valid is
// high for one cycle with status, key_out, payload_out and entry_count. The
// receiver cannot stall; a result must be taken in the cycle it is shown.
// A failed push or pop answers in the cycle after acceptance. A push writes
// one entry per level climbed, a pop one per level descended; their length is
// set by the single read port of the entry memory, which is read once per
// parent and twice per child pair. busy drops in the same cycle that
// result_valid rises, so the next transaction may be accepted while the
// result is shown. smallest_first is written through cfg_we/cfg_wdata; the
// user must write it only while idle, as the block does not enforce this.
// Reset empties the queue and selects largest-first; memory is not cleared,
// since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_wdata,
    input  logic                      start,
    output logic                      busy,
    input  logic                      opcode,
    input  logic [hpq_pkg::KEY_W-1:0] key_in,
    input  logic [hpq_pkg::PAY_W-1:0] payload_in,
    output logic                      result_valid,
    output logic [1:0]                status,
    output logic [hpq_pkg::KEY_W-1:0] key_out,
    output logic [hpq_pkg::PAY_W-1:0] payload_out,
    output logic [hpq_pkg::CNT_W-1:0] entry_count
);

    import hpq_pkg::*;

    // Configuration: 0 serves the largest key first, 1 the smallest.
    logic              smallest_first_reg;

    // Result registers; the strobe is the only one that needs a reset.
    logic              result_valid_reg;
    status_t           status_reg;
    logic [KEY_W-1:0]  key_out_reg;
    logic [PAY_W-1:0]  payload_out_reg;
    logic [CNT_W-1:0]  entry_count_reg;

    mem_req_t          mem_req;
    res_t              res;
    logic [$bits(entry_t)-1:0] ram_rd_data;
    entry_t            rd_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smallest_first_reg <= 1'b0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                smallest_first_reg <= cfg_wdata;
            end
            result_valid_reg <= res.valid;
        end
    end

    // Results are captured when the sequencer finishes, then shown for one cycle.
    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            status_reg      <= res.status;
            key_out_reg     <= res.key;
            payload_out_reg <= res.payload;
            entry_count_reg <= res.count;
        end
    end

    hpq_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .opcode         (opcode),
        .key_in         (key_in),
        .payload_in     (payload_in),
        .smallest_first (smallest_first_reg),
        .rd_data        (rd_entry),
        .busy           (busy),
        .mem_req        (mem_req),
        .res            (res)
    );

    // Keys and payloads share one memory word per heap slot.
    hpq_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W ($bits(entry_t))
    ) u_ram (
        .clk     (clk),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data)
    );

    assign rd_entry     = entry_t'(ram_rd_data);
    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign key_out      = key_out_reg;
    assign payload_out  = payload_out_reg;
    assign entry_count  = entry_count_reg;

endmodule
